[hw/rtl/mfaf_pkg.sv]
package mfaf_pkg;

  localparam int HASH_W   = 64;
  localparam int SCORE_W  = 8;
  localparam int THR_W    = 9;
  localparam int IVL_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 8'd255;

  // Table geometry, both powers of two
  localparam int SHARDS  = 16;
  localparam int ENTRIES = 64;

  // Operation kinds
  localparam logic [1:0] KIND_MISS  = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_NOOP  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_INTERVAL  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLR,      // sweep the slot table after reset
    ST_IDLE,
    ST_DECAY,    // halve every score in the shard, one slot a cycle
    ST_SCAN,     // search the shard for the key, free slot and victim
    ST_UPDATE    // write back the chosen slot once the result register is free
  } mfaf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic decay_start;
    logic decay_step;
    logic scan_start;
    logic scan_step;
    logic update;
    logic out_load;
  } mfaf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic need_decay;
    logic decay_done;
    logic scan_done;
  } mfaf_sts_t;

endpackage

[hw/rtl/mfaf_ctrl.sv]
module mfaf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  mfaf_pkg::mfaf_sts_t sts,
  output mfaf_pkg::mfaf_cmd_t cmd
);

  mfaf_pkg::mfaf_state_t state_r, state_nxt;
  logic                  busy_out_r, busy_out_nxt;
  logic                  out_free;

  // result register can take a new item this cycle
  assign out_free = !busy_out_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfaf_pkg::ST_CLR:    if (sts.clr_done) state_nxt = mfaf_pkg::ST_IDLE;
      mfaf_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = mfaf_pkg::ST_SCAN;
      end
      mfaf_pkg::ST_SCAN: begin
        // first cycle after capture decides on decay
        if (sts.need_decay) state_nxt = mfaf_pkg::ST_DECAY;
        else if (sts.scan_done) state_nxt = mfaf_pkg::ST_UPDATE;
      end
      mfaf_pkg::ST_DECAY:  if (sts.decay_done) state_nxt = mfaf_pkg::ST_SCAN;
      mfaf_pkg::ST_UPDATE: if (out_free) state_nxt = mfaf_pkg::ST_IDLE;
      default:             state_nxt = mfaf_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    in_tready    = 1'b0;
    busy_out_nxt = busy_out_r;
    if (busy_out_r && out_tready) busy_out_nxt = 1'b0;
    case (state_r)
      mfaf_pkg::ST_CLR:  cmd.clr_step = 1'b1;
      mfaf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
        end
      end
      mfaf_pkg::ST_SCAN: begin
        if (sts.need_decay) cmd.decay_start = 1'b1;
        else cmd.scan_step = 1'b1;
      end
      mfaf_pkg::ST_DECAY: begin
        cmd.decay_step = 1'b1;
        if (sts.decay_done) cmd.scan_start = 1'b1;
      end
      mfaf_pkg::ST_UPDATE: begin
        // hold the write-back until the previous result is gone
        if (out_free) begin
          cmd.update   = 1'b1;
          cmd.out_load = 1'b1;
          busy_out_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = busy_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mfaf_pkg::ST_CLR;
      busy_out_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      busy_out_r <= busy_out_nxt;
    end
  end

endmodule

[hw/rtl/mfaf_dp.sv]
module mfaf_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mfaf_pkg::mfaf_cmd_t            cmd,
  output mfaf_pkg::mfaf_sts_t            sts,
  input  logic [1:0]                     in_kind,
  input  logic [mfaf_pkg::HASH_W-1:0]    in_hash,
  input  logic [mfaf_pkg::THR_W-1:0]     thr,
  input  logic [mfaf_pkg::IVL_W-1:0]     ivl,
  output logic                           res_ready,
  output logic                           res_present,
  output logic [mfaf_pkg::SCORE_W-1:0]   res_score
);

  localparam int SHARDS  = mfaf_pkg::SHARDS;
  localparam int ENTRIES = mfaf_pkg::ENTRIES;
  localparam int SH_W    = (SHARDS > 1) ? $clog2(SHARDS) : 1;
  localparam int EN_W    = $clog2(ENTRIES);
  localparam int TOTAL   = SHARDS * ENTRIES;
  localparam int ADDR_W  = $clog2(TOTAL);
  localparam int CNT_W   = EN_W + 1;

  // Slot memories: hash, score, valid packed into one word for score/valid
  logic [mfaf_pkg::HASH_W-1:0]  hash_mem  [TOTAL];
  logic [mfaf_pkg::SCORE_W:0]   sv_mem    [TOTAL];   // {valid, score}
  logic [mfaf_pkg::IVL_W-1:0]   opcnt_r   [SHARDS];

  logic [1:0]                   kind_r;
  logic [mfaf_pkg::HASH_W-1:0]  key_r;
  logic [SH_W-1:0]              shard_r;
  logic [CNT_W-1:0]             idx_r, idx_nxt;    // read pointer
  logic                         rd_vld_r;          // read data valid
  logic [EN_W-1:0]              rd_idx_r;          // slot of read data
  logic                         decay_chk_r;       // decay decision pending
  logic [ADDR_W-1:0]            clr_addr_r;
  logic                         clr_done_r;

  logic [mfaf_pkg::HASH_W-1:0]  rd_hash_r;
  logic [mfaf_pkg::SCORE_W:0]   rd_sv_r;

  // Scan results
  logic                         hit_r, free_r, vict_r;
  logic [EN_W-1:0]              hit_idx_r, free_idx_r, vict_idx_r;
  logic [mfaf_pkg::SCORE_W-1:0] hit_score_r;

  logic [ADDR_W-1:0]            rd_addr, wr_addr_dec;
  logic [mfaf_pkg::IVL_W-1:0]   cnt_inc, limit;
  logic                         counts;
  logic                         is_noop;
  logic [mfaf_pkg::SCORE_W-1:0] half;
  logic                         decaying_r;

  // Write-back decision
  logic                         in_kind_w_miss, in_kind_w_clr, upd_en, upd_new;
  logic [ADDR_W-1:0]            upd_addr;
  logic [mfaf_pkg::SCORE_W:0]   upd_sv;
  logic [EN_W-1:0]              upd_idx;
  logic [mfaf_pkg::SCORE_W-1:0] new_score;
  logic                         held;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SH_W-1:0] sh,
                                                  input logic [EN_W-1:0] e);
    return ADDR_W'(sh) * ADDR_W'(ENTRIES) + ADDR_W'(e);
  endfunction

  assign counts  = (kind_r == mfaf_pkg::KIND_MISS) || (kind_r == mfaf_pkg::KIND_CHECK);
  assign is_noop = (kind_r == mfaf_pkg::KIND_NOOP);
  assign cnt_inc = opcnt_r[shard_r] + 1'b1;
  assign limit   = (ivl == '0) ? mfaf_pkg::IVL_W'(1) : ivl;
  assign rd_addr = slot_addr(shard_r, idx_r[EN_W-1:0]);
  assign wr_addr_dec = slot_addr(shard_r, rd_idx_r);
  assign half    = rd_sv_r[mfaf_pkg::SCORE_W-1:0] >> 1;

  assign sts.clr_done   = clr_done_r;
  assign sts.need_decay = decay_chk_r && counts && (cnt_inc >= limit);
  assign sts.decay_done = decaying_r && !rd_vld_r && idx_r[EN_W] ;
  assign sts.scan_done  = !decay_chk_r && !rd_vld_r && idx_r[EN_W];

  // Pointer: walks all slots of the shard, one read a cycle
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.capture || cmd.decay_start || cmd.scan_start) idx_nxt = '0;
    else if ((cmd.scan_step || cmd.decay_step) && !idx_r[EN_W] && !decay_chk_r)
      idx_nxt = idx_r + 1'b1;
  end

  assign in_kind_w_miss = (kind_r == mfaf_pkg::KIND_MISS);
  assign in_kind_w_clr  = (kind_r == mfaf_pkg::KIND_CLEAR);

  always_comb begin
    upd_new   = 1'b0;
    upd_en    = 1'b0;
    upd_idx   = hit_idx_r;
    new_score = hit_score_r;
    held      = 1'b0;
    upd_sv    = '0;
    if (in_kind_w_miss) begin
      if (hit_r) begin
        upd_en    = 1'b1;
        held      = 1'b1;
        if (hit_score_r != mfaf_pkg::SCORE_MAX) new_score = hit_score_r + 1'b1;
      end else if (free_r || vict_r) begin
        upd_en    = 1'b1;
        upd_new   = 1'b1;
        held      = 1'b1;
        upd_idx   = free_r ? free_idx_r : vict_idx_r;
        new_score = mfaf_pkg::SCORE_W'(1);
      end
      upd_sv = {1'b1, new_score};
    end else if (in_kind_w_clr) begin
      upd_en = hit_r;
    end else if (kind_r == mfaf_pkg::KIND_CHECK) begin
      held = hit_r;
    end
  end
  assign upd_addr = slot_addr(shard_r, upd_idx);

  // Memory reads and writes
  always_ff @(posedge clk) begin
    rd_hash_r <= hash_mem[rd_addr];
    rd_sv_r   <= sv_mem[rd_addr];
    if (cmd.clr_step && !clr_done_r) sv_mem[clr_addr_r] <= '0;
    else if (decaying_r && rd_vld_r && rd_sv_r[mfaf_pkg::SCORE_W])
      sv_mem[wr_addr_dec] <= {(half != '0), half};
    else if (cmd.update && (in_kind_w_miss || in_kind_w_clr) && upd_en)
      sv_mem[upd_addr] <= upd_sv;
    if (cmd.update && in_kind_w_miss && upd_new) hash_mem[upd_addr] <= key_r;
  end

  // Control and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      clr_done_r  <= 1'b0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      decay_chk_r <= 1'b0;
      decaying_r  <= 1'b0;
      for (int s = 0; s < SHARDS; s++) opcnt_r[s] <= '0;
    end else begin
      if (cmd.clr_step && !clr_done_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(TOTAL - 1)) clr_done_r <= 1'b1;
      end
      idx_r    <= idx_nxt;
      rd_vld_r <= (cmd.scan_step || cmd.decay_step) && !idx_r[EN_W] && !decay_chk_r;
      rd_idx_r <= idx_r[EN_W-1:0];
      if (cmd.capture) decay_chk_r <= 1'b1;
      else if (cmd.scan_step || cmd.decay_start) decay_chk_r <= 1'b0;
      if (cmd.decay_start) decaying_r <= 1'b1;
      else if (cmd.scan_start) decaying_r <= 1'b0;
      // counter advances once per miss or check op, at the decay decision
      if (decay_chk_r && (cmd.scan_step || cmd.decay_start) && counts)
        opcnt_r[shard_r] <= (cnt_inc >= limit) ? '0 : cnt_inc;
    end
  end

  // Item capture and scan accumulation
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      key_r   <= in_hash;
      shard_r <= SH_W'(in_hash % SHARDS);
    end
    if (cmd.capture || cmd.scan_start) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      vict_r <= 1'b0;
    end else if (rd_vld_r && !decaying_r) begin
      if (rd_sv_r[mfaf_pkg::SCORE_W] && rd_hash_r == key_r && !hit_r) begin
        hit_r       <= 1'b1;
        hit_idx_r   <= rd_idx_r;
        hit_score_r <= rd_sv_r[mfaf_pkg::SCORE_W-1:0];
      end
      if (!rd_sv_r[mfaf_pkg::SCORE_W] && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (rd_sv_r[mfaf_pkg::SCORE_W-1:0] <= mfaf_pkg::SCORE_W'(1) && !vict_r) begin
        vict_r     <= 1'b1;
        vict_idx_r <= rd_idx_r;
      end
    end
    if (cmd.out_load) begin
      res_present <= held && !is_noop;
      res_score   <= (held && !is_noop) ? new_score : '0;
      res_ready   <= (kind_r == mfaf_pkg::KIND_CHECK) && hit_r &&
                     ({1'b0, hit_score_r} >= ((thr == '0) ? mfaf_pkg::THR_W'(1) : thr));
    end
  end

endmodule

[hw/rtl/miss_frequency_admission_filter.sv]
// Frequency-counting admission filter. Each item (kind on in_tuser, key hash
// on in_tdata) gives one result. After reset the slot table is cleared, and
// in_tready stays low meanwhile. An item then passes through an accept step,
// a counter step, a scan of the shard (one slot read per cycle from the
// slot memory, whose read data is registered) and a write-back step, which
// also loads its result. When the shard's decay interval expires, all its
// valid scores are halved first. One item is processed at a time; a new item
// may be accepted while the prior result waits, but its write-back stalls
// until that result has been taken.
module miss_frequency_admission_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic [63:0] in_tdata,   // hash[63:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // ready_res[0], present[1], score[9:2], zero pad
  input  logic        cfg_we,
  input  logic [mfaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  mfaf_pkg::mfaf_cmd_t        cmd;
  mfaf_pkg::mfaf_sts_t        sts;
  logic [mfaf_pkg::THR_W-1:0] thr_r;
  logic [mfaf_pkg::IVL_W-1:0] ivl_r;
  logic                       res_ready, res_present;
  logic [7:0]                 res_score;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 9'd2;
      ivl_r <= 16'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        mfaf_pkg::CFG_THRESHOLD: thr_r <= cfg_wdata[mfaf_pkg::THR_W-1:0];
        mfaf_pkg::CFG_INTERVAL:  ivl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mfaf_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .sts, .cmd
  );

  mfaf_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_kind (in_tuser),
    .in_hash (in_tdata),
    .thr     (thr_r),
    .ivl     (ivl_r),
    .res_ready, .res_present, .res_score
  );

  assign out_tdata = {6'd0, res_score, res_present, res_ready};

`ifndef SYNTH
  // no result appears without a finished operation
  a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.update)) else $error("spurious result");
  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while waiting");
  // decay and capture never coincide
  a_decay_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.decay_step)) else $error("decay during capture");
`endif

endmodule

[tb/tb_miss_frequency_admission_filter.sv]
`timescale 1ns / 100ps

module tb_miss_frequency_admission_filter;

  localparam int SHARDS = mfaf_pkg::SHARDS;
  localparam int ENTRIES = mfaf_pkg::ENTRIES;
  localparam int SLOTS = SHARDS * ENTRIES;
  localparam int HASH_W = mfaf_pkg::HASH_W;
  localparam int SCORE_W = mfaf_pkg::SCORE_W;
  localparam int THR_W = mfaf_pkg::THR_W;
  localparam int IVL_W = mfaf_pkg::IVL_W;
  localparam int STALL_LIMIT = 20000;
  localparam int HOT_KEYS = 100;
  localparam int WARM_KEYS = 40;

  // Packed in out_tdata order, lowest bit last
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic present;
    logic ready_res;
  } verdict_t;

  typedef struct {
    logic [1:0] kind;
    logic [HASH_W-1:0] key;
    bit typed;
    verdict_t verdict;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [mfaf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  miss_frequency_admission_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the slot table and registers
  logic [HASH_W-1:0] slot_hash [SLOTS];
  bit [SCORE_W-1:0] slot_score [SLOTS];
  bit slot_valid [SLOTS];
  bit [IVL_W-1:0] shard_ops [SHARDS];
  bit [THR_W-1:0] thr_reg = 9'd2;
  bit [IVL_W-1:0] ivl_reg = 16'd1024;

  verdict_t verdict_q [$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  logic [HASH_W-1:0] hot_pool [HOT_KEYS];
  logic [HASH_W-1:0] warm_pool [WARM_KEYS];

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Bump the shard's counter; halve the shard's scores when it expires
  function automatic void age_shard(input int sh);
    int lim;
    lim = (ivl_reg == 0) ? 1 : int'(ivl_reg);
    shard_ops[sh] = shard_ops[sh] + 16'd1;
    if (int'(shard_ops[sh]) >= lim) begin
      shard_ops[sh] = '0;
      for (int i = sh * ENTRIES; i < (sh + 1) * ENTRIES; i++) begin
        if (slot_valid[i]) begin
          slot_score[i] = slot_score[i] >> 1;
          if (slot_score[i] == 0) slot_valid[i] = 1'b0;
        end
      end
    end
  endfunction

  function automatic int lookup_slot(input int sh, input logic [HASH_W-1:0] key);
    for (int i = sh * ENTRIES; i < (sh + 1) * ENTRIES; i++)
      if (slot_valid[i] && slot_hash[i] == key) return i;
    return -1;
  endfunction

  function automatic verdict_t admit_verdict(input logic [1:0] kind,
                                             input logic [HASH_W-1:0] key);
    verdict_t v;
    int sh, slot, thr;
    v = '0;
    sh = int'(key % SHARDS);
    thr = (thr_reg == 0) ? 1 : int'(thr_reg);
    case (kind)
      mfaf_pkg::KIND_MISS: begin
        age_shard(sh);
        slot = lookup_slot(sh, key);
        if (slot >= 0) begin
          if (slot_score[slot] != mfaf_pkg::SCORE_MAX) slot_score[slot]++;
        end else begin
          for (int i = sh * ENTRIES; i < (sh + 1) * ENTRIES && slot < 0; i++)
            if (!slot_valid[i]) slot = i;
          for (int i = sh * ENTRIES; i < (sh + 1) * ENTRIES && slot < 0; i++)
            if (slot_score[i] <= 1) slot = i;
          if (slot >= 0) begin
            slot_hash[slot] = key;
            slot_score[slot] = 8'd1;
            slot_valid[slot] = 1'b1;
          end
        end
        if (slot >= 0) begin
          v.present = 1'b1;
          v.score = slot_score[slot];
        end
      end
      mfaf_pkg::KIND_CHECK: begin
        age_shard(sh);
        slot = lookup_slot(sh, key);
        if (slot >= 0) begin
          v.ready_res = (int'(slot_score[slot]) >= thr);
          v.present = 1'b1;
          v.score = slot_score[slot];
        end
      end
      mfaf_pkg::KIND_CLEAR: begin
        slot = lookup_slot(sh, key);
        if (slot >= 0) begin
          slot_valid[slot] = 1'b0;
          slot_score[slot] = '0;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // Offer one item; on acceptance queue its verdict
  task automatic send_item(input logic [1:0] kind, input logic [HASH_W-1:0] key,
                           input bit typed, input verdict_t typed_v);
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = admit_verdict(kind, key);
    verdict_q.insert(verdict_q.size(), typed ? typed_v : v);
  endtask

  task automatic drain_and_setup(input logic [15:0] thr, input logic [15:0] ivl);
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mfaf_pkg::CFG_THRESHOLD;
    cfg_wdata <= thr;
    thr_reg = thr[THR_W-1:0];
    @(posedge clk);
    cfg_index <= mfaf_pkg::CFG_INTERVAL;
    cfg_wdata <= ivl;
    ivl_reg = ivl;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [HASH_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Random key that lands in the given shard
  function automatic logic [HASH_W-1:0] shard_key(input int sh);
    logic [HASH_W-1:0] r;
    r = rand_key();
    return r - (r % SHARDS) + HASH_W'(sh);
  endfunction

  task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
    logic [1:0] kind;
    logic [HASH_W-1:0] key;
    int r;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      kind = (r < 55) ? mfaf_pkg::KIND_MISS :
             (r < 85) ? mfaf_pkg::KIND_CHECK :
             (r < 95) ? mfaf_pkg::KIND_CLEAR : mfaf_pkg::KIND_NOOP;
      r = $urandom_range(0, 99);
      if (r < 55) key = hot_pool[$urandom_range(0, HOT_KEYS - 1)];
      else if (r < 85) key = warm_pool[$urandom_range(0, WARM_KEYS - 1)];
      else key = rand_key();
      send_item(kind, key, 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure and in-order comparison
  always @(posedge clk) begin
    verdict_t got, want;
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (out_tvalid && out_tready) begin
      got = out_tdata[9:0];
      if (verdict_q.size() == 0) begin
        report_err($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = verdict_q[0];
        verdict_q.delete(0);
        if (got.ready_res !== want.ready_res)
          report_err($sformatf("ready_res %b, want %b", got.ready_res, want.ready_res));
        if (got.present !== want.present)
          report_err($sformatf("present %b, want %b", got.present, want.present));
        if (got.score !== want.score)
          report_err($sformatf("score %0d, want %0d", got.score, want.score));
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [15];
    logic [HASH_W-1:0] key_a, key_b, fill_key;

    for (int i = 0; i < SLOTS; i++) begin
      slot_hash[i] = '0;
      slot_score[i] = '0;
      slot_valid[i] = 1'b0;
    end
    for (int i = 0; i < SHARDS; i++) shard_ops[i] = '0;
    for (int i = 0; i < HOT_KEYS; i++) hot_pool[i] = shard_key(3);
    for (int i = 0; i < WARM_KEYS; i++) warm_pool[i] = rand_key();
    key_a = shard_key(9);
    key_b = {$urandom(), 28'h0, 4'd9};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: defaults are threshold 2, interval 1024
    rows[0] = '{mfaf_pkg::KIND_CHECK, key_a, 1'b1, verdict_t'{8'd0, 1'b0, 1'b0}};
    rows[1] = '{mfaf_pkg::KIND_MISS, key_a, 1'b1, verdict_t'{8'd1, 1'b1, 1'b0}};
    rows[2] = '{mfaf_pkg::KIND_CHECK, key_a, 1'b1, verdict_t'{8'd1, 1'b1, 1'b0}};
    rows[3] = '{mfaf_pkg::KIND_MISS, key_a, 1'b1, verdict_t'{8'd2, 1'b1, 1'b0}};
    rows[4] = '{mfaf_pkg::KIND_CHECK, key_a, 1'b1, verdict_t'{8'd2, 1'b1, 1'b1}};
    rows[5] = '{mfaf_pkg::KIND_MISS, key_b, 1'b0, '0};
    rows[6] = '{mfaf_pkg::KIND_CLEAR, key_a, 1'b1, verdict_t'{8'd0, 1'b0, 1'b0}};
    rows[7] = '{mfaf_pkg::KIND_CHECK, key_a, 1'b1, verdict_t'{8'd0, 1'b0, 1'b0}};
    rows[8] = '{mfaf_pkg::KIND_CHECK, key_b, 1'b0, '0};
    rows[9] = '{mfaf_pkg::KIND_CLEAR, key_a, 1'b1, verdict_t'{8'd0, 1'b0, 1'b0}};
    rows[10] = '{mfaf_pkg::KIND_NOOP, key_b, 1'b1, verdict_t'{8'd0, 1'b0, 1'b0}};
    rows[11] = '{mfaf_pkg::KIND_MISS, {HASH_W{1'b1}}, 1'b1,
                 verdict_t'{8'd1, 1'b1, 1'b0}};
    rows[12] = '{mfaf_pkg::KIND_MISS, {HASH_W{1'b0}}, 1'b1,
                 verdict_t'{8'd1, 1'b1, 1'b0}};
    rows[13] = '{mfaf_pkg::KIND_CHECK, {HASH_W{1'b1}}, 1'b1,
                 verdict_t'{8'd1, 1'b1, 1'b0}};
    rows[14] = '{mfaf_pkg::KIND_CLEAR, {HASH_W{1'b0}}, 1'b1,
                 verdict_t'{8'd0, 1'b0, 1'b0}};
    foreach (rows[i]) send_item(rows[i].kind, rows[i].key, rows[i].typed, rows[i].verdict);

    // Saturation at the top score, no decay in the way
    drain_and_setup(16'd200, 16'd65535);
    for (int i = 0; i < 258; i++) send_item(mfaf_pkg::KIND_MISS, key_b, 1'b0, '0);
    send_item(mfaf_pkg::KIND_CHECK, key_b, 1'b1, verdict_t'{8'd255, 1'b1, 1'b1});

    // Fill shard 5 with scores of 2, then a new key finds no victim
    for (int i = 0; i < ENTRIES; i++) begin
      fill_key = shard_key(5);
      send_item(mfaf_pkg::KIND_MISS, fill_key, 1'b0, '0);
      send_item(mfaf_pkg::KIND_MISS, fill_key, 1'b0, '0);
    end
    send_item(mfaf_pkg::KIND_MISS, shard_key(5), 1'b1, verdict_t'{8'd0, 1'b0, 1'b0});

    // Random phases over register settings and idle and stall patterns
    drain_and_setup(16'd0, 16'd1);
    random_phase(135, 0, 0);
    drain_and_setup(16'd256, 16'd0);
    random_phase(135, 72, 0);
    drain_and_setup(16'd511, 16'd65535);
    random_phase(135, 0, 72);
    drain_and_setup(16'd3, 16'd7);
    random_phase(135, 10, 10);
    drain_and_setup(16'd1, 16'd3);
    random_phase(135, 0, 0);
    drain_and_setup(16'd2, 16'd40);
    random_phase(80, 72, 72);

    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
